### sv/tpi_pkg.sv
package tpi_pkg;

  localparam int MAX_POINTS = 64;
  localparam int PT_ADDR_W  = $clog2(MAX_POINTS);
  localparam int PT_CNT_W   = $clog2(MAX_POINTS + 1);

  localparam int CMD_W      = 2;
  localparam int IDX_W      = 6;
  localparam int TIME_W     = 16;
  localparam int TEMP_W     = 16;
  localparam int MS_W       = 32;
  localparam int CFG_W      = 7;

  // largest elapsed seconds value is (2^32 - 1) / 1000, which needs 23 bits
  localparam int ELAPSED_W  = 23;
  localparam int MS_PER_S   = 1000;

  // serial arithmetic units
  localparam int MUL_W      = 16;
  localparam int MUL_CNT_W  = $clog2(MUL_W);
  localparam int DIV_NUM_W  = 32;
  localparam int DIV_DEN_W  = 16;
  localparam int DIV_CNT_W  = $clog2(DIV_NUM_W);

  localparam int ENTRY_W    = TIME_W + TEMP_W;

  typedef logic [CMD_W-1:0]         cmd_t;
  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [TIME_W-1:0]        ptime_t;
  typedef logic signed [TEMP_W-1:0] temp_t;
  typedef logic [MS_W-1:0]          ms_t;
  typedef logic [CFG_W-1:0]         cfg_t;

  localparam cmd_t CMD_WRITE = 2'd0;
  localparam cmd_t CMD_START = 2'd1;
  localparam cmd_t CMD_STOP  = 2'd2;
  localparam cmd_t CMD_QUERY = 2'd3;

endpackage

### sv/tpi_ram.sv
module tpi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### sv/tpi_serial_mul.sv
module tpi_serial_mul (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  go,
  input  logic [tpi_pkg::MUL_W-1:0]             mcand,
  input  logic [tpi_pkg::MUL_W-1:0]             mplier,
  output logic                                  done,
  output logic [2*tpi_pkg::MUL_W-1:0]           product
);

  import tpi_pkg::*;

  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [MUL_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [MUL_W-1:0]       mcand_r, mcand_nxt;
  logic [2*MUL_W-1:0]     prod_r, prod_nxt;
  logic [MUL_W:0]         sum;

  // shift-add, one multiplier bit per cycle, low half holds the multiplier
  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    mcand_nxt = mcand_r;
    prod_nxt  = prod_r;
    sum = {1'b0, prod_r[2*MUL_W-1:MUL_W]} + (prod_r[0] ? {1'b0, mcand_r} : '0);
    if (go) begin
      busy_nxt  = 1'b1;
      cnt_nxt   = '0;
      mcand_nxt = mcand;
      prod_nxt  = {{MUL_W{1'b0}}, mplier};
    end else if (busy_r) begin
      prod_nxt = {sum, prod_r[MUL_W-1:1]};
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == MUL_CNT_W'(MUL_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mcand_r <= mcand_nxt;
    prod_r  <= prod_nxt;
  end

  assign done    = done_r;
  assign product = prod_r;

endmodule

### sv/tpi_serial_div.sv
module tpi_serial_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          go,
  input  logic [tpi_pkg::DIV_NUM_W-1:0] dividend,
  input  logic [tpi_pkg::DIV_DEN_W-1:0] divisor,
  output logic                          done,
  output logic [tpi_pkg::DIV_NUM_W-1:0] quotient
);

  import tpi_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_DEN_W-1:0] den_r, den_nxt;
  logic [DIV_DEN_W-1:0] rem_r, rem_nxt;
  logic [DIV_NUM_W-1:0] quo_r, quo_nxt;
  logic [DIV_DEN_W:0]   shifted;
  logic [DIV_DEN_W:0]   trial;
  logic                 fits;

  // restoring division, one quotient bit per cycle; dividend bits shift out
  // of the top of quo_r while quotient bits shift in at the bottom
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    shifted  = {rem_r, quo_r[DIV_NUM_W-1]};
    trial    = shifted - {1'b0, den_r};
    fits     = shifted >= {1'b0, den_r};
    if (go) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      den_nxt  = divisor;
      rem_nxt  = '0;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = fits ? trial[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
      quo_nxt = {quo_r[DIV_NUM_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### sv/temperature_profile_interpolator_unit.sv
// write, start and stop items: result strobe one cycle after accept, next item the cycle after.
// query items: elapsed seconds by serial divide by 1000, then a scan of the point table (one read
// per cycle), then a serial multiply and a serial divide; an answer at an end point skips the
// multiply and divide, and when stopped the result strobe comes the cycle after accept.
// reset (synchronous, rst_n low) clears run flag, start time and point count; the point table
// is not cleared; results cannot be stalled and show for one cycle on out_valid.
module temperature_profile_interpolator_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  tpi_pkg::cmd_t         in_cmd,
  input  tpi_pkg::idx_t         in_point_index,
  input  tpi_pkg::ptime_t       in_point_time,
  input  tpi_pkg::temp_t        in_point_temp,
  input  tpi_pkg::ms_t          in_now_ms,
  output logic                  out_valid,
  output tpi_pkg::temp_t        out_setpoint,
  output logic                  out_running,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  tpi_pkg::cfg_t         cfg_points_in_use
);

  import tpi_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIVE = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_DIVQ = 3'd4;

  logic [2:0]            state_r, state_nxt;
  logic                  run_r, run_nxt;
  ms_t                   start_ms_r, start_ms_nxt;
  cfg_t                  pts_r;
  logic                  out_valid_r, out_valid_nxt;
  temp_t                 out_temp_r, out_temp_nxt;
  logic                  out_run_r, out_run_nxt;

  logic [ELAPSED_W-1:0]  elapsed_r, elapsed_nxt;
  logic [PT_CNT_W-1:0]   rd_k_r, rd_k_nxt;
  logic [PT_CNT_W-1:0]   ev_k_r, ev_k_nxt;
  logic                  rdv_r, rdv_nxt;
  ptime_t                prev_time_r, prev_time_nxt;
  temp_t                 prev_temp_r, prev_temp_nxt;
  temp_t                 first_temp_r, first_temp_nxt;
  temp_t                 base_temp_r, base_temp_nxt;
  logic                  neg_r, neg_nxt;
  ptime_t                den_r, den_nxt;

  logic                  accept;
  logic [PT_CNT_W-1:0]   n_pts;
  logic [PT_CNT_W-1:0]   last_k;
  logic                  ram_we;
  logic [ENTRY_W-1:0]    ram_q;
  ptime_t                cur_time;
  temp_t                 cur_temp;
  logic                  hit;
  logic [TEMP_W:0]       delta;
  logic [TEMP_W:0]       delta_mag;
  logic [TEMP_W:0]       q_ext;
  logic [TEMP_W:0]       interp;

  logic                  mul_go, mul_done;
  logic [MUL_W-1:0]      mul_a, mul_b;
  logic [2*MUL_W-1:0]    mul_p;
  logic                  div_go, div_done;
  logic [DIV_NUM_W-1:0]  div_num, div_quo;
  logic [DIV_DEN_W-1:0]  div_den;

  assign accept    = start && (state_r == S_IDLE);
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);

  // point count saturates at the table size
  assign n_pts  = (32'(pts_r) > MAX_POINTS) ? PT_CNT_W'(MAX_POINTS) : PT_CNT_W'(pts_r);
  assign last_k = n_pts - 1'b1;

  assign ram_we   = accept && (in_cmd == CMD_WRITE) && (32'(in_point_index) < MAX_POINTS);
  assign cur_time = ram_q[ENTRY_W-1:TEMP_W];
  assign cur_temp = temp_t'(ram_q[TEMP_W-1:0]);

  assign hit = rdv_r && (ev_k_r != '0)
            && (elapsed_r >= ELAPSED_W'(prev_time_r))
            && (elapsed_r < ELAPSED_W'(cur_time));

  assign delta     = {cur_temp[TEMP_W-1], cur_temp} - {prev_temp_r[TEMP_W-1], prev_temp_r};
  assign delta_mag = delta[TEMP_W] ? ((TEMP_W+1)'(0) - delta) : delta;
  assign q_ext     = {1'b0, div_quo[TEMP_W-1:0]};
  assign interp    = {base_temp_r[TEMP_W-1], base_temp_r}
                   + (neg_r ? ((TEMP_W+1)'(0) - q_ext) : q_ext);

  tpi_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_POINTS)
  ) u_points (
    .clk   (clk),
    .we    (ram_we),
    .waddr (PT_ADDR_W'(in_point_index)),
    .wdata ({in_point_time, in_point_temp}),
    .raddr (rd_k_r[PT_ADDR_W-1:0]),
    .rdata (ram_q)
  );

  tpi_serial_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (mul_go),
    .mcand   (mul_a),
    .mplier  (mul_b),
    .done    (mul_done),
    .product (mul_p)
  );

  tpi_serial_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    state_nxt      = state_r;
    run_nxt        = run_r;
    start_ms_nxt   = start_ms_r;
    out_valid_nxt  = 1'b0;
    out_temp_nxt   = out_temp_r;
    out_run_nxt    = out_run_r;
    elapsed_nxt    = elapsed_r;
    rd_k_nxt       = rd_k_r;
    ev_k_nxt       = ev_k_r;
    rdv_nxt        = 1'b0;
    prev_time_nxt  = prev_time_r;
    prev_temp_nxt  = prev_temp_r;
    first_temp_nxt = first_temp_r;
    base_temp_nxt  = base_temp_r;
    neg_nxt        = neg_r;
    den_nxt        = den_r;
    mul_go         = 1'b0;
    mul_a          = delta_mag[MUL_W-1:0];
    mul_b          = MUL_W'(elapsed_r[TIME_W-1:0] - prev_time_r);
    div_go         = 1'b0;
    div_num        = in_now_ms - start_ms_r;
    div_den        = DIV_DEN_W'(MS_PER_S);

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_cmd)
            CMD_WRITE: begin
              out_valid_nxt = 1'b1;
              out_temp_nxt  = '0;
              out_run_nxt   = run_r;
            end
            CMD_START: begin
              start_ms_nxt  = in_now_ms;
              run_nxt       = 1'b1;
              out_valid_nxt = 1'b1;
              out_temp_nxt  = '0;
              out_run_nxt   = 1'b1;
            end
            CMD_STOP: begin
              run_nxt       = 1'b0;
              out_valid_nxt = 1'b1;
              out_temp_nxt  = '0;
              out_run_nxt   = 1'b0;
            end
            default: begin
              if (!run_r || (n_pts == '0)) begin
                out_valid_nxt = 1'b1;
                out_temp_nxt  = '0;
                out_run_nxt   = run_r;
              end else begin
                div_go    = 1'b1;
                state_nxt = S_DIVE;
              end
            end
          endcase
        end
      end

      S_DIVE: begin
        if (div_done) begin
          elapsed_nxt = div_quo[ELAPSED_W-1:0];
          rd_k_nxt    = '0;
          state_nxt   = S_SCAN;
        end
      end

      S_SCAN: begin
        // one table read issued per cycle, its data compared the cycle after
        if (rd_k_r < n_pts) begin
          rdv_nxt  = 1'b1;
          ev_k_nxt = rd_k_r;
          rd_k_nxt = rd_k_r + 1'b1;
        end
        if (rdv_r) begin
          if (ev_k_r == '0) begin
            first_temp_nxt = cur_temp;
          end
          prev_time_nxt = cur_time;
          prev_temp_nxt = cur_temp;
          if (hit) begin
            base_temp_nxt = prev_temp_r;
            neg_nxt       = delta[TEMP_W];
            den_nxt       = cur_time - prev_time_r;
            mul_go        = 1'b1;
            state_nxt     = S_MUL;
          end else if (ev_k_r == last_k) begin
            // no bracketing segment: clamp to an end point
            out_valid_nxt = 1'b1;
            out_run_nxt   = run_r;
            if ((elapsed_r >= ELAPSED_W'(cur_time)) || (ev_k_r == '0)) begin
              out_temp_nxt = cur_temp;
            end else begin
              out_temp_nxt = first_temp_r;
            end
            state_nxt = S_IDLE;
          end
        end
      end

      S_MUL: begin
        div_num = mul_p;
        div_den = den_r;
        if (mul_done) begin
          div_go    = 1'b1;
          state_nxt = S_DIVQ;
        end
      end

      S_DIVQ: begin
        if (div_done) begin
          out_valid_nxt = 1'b1;
          out_temp_nxt  = temp_t'(interp[TEMP_W-1:0]);
          out_run_nxt   = run_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      run_r       <= 1'b0;
      start_ms_r  <= '0;
      pts_r       <= '0;
      out_valid_r <= 1'b0;
      rdv_r       <= 1'b0;
      rd_k_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      run_r       <= run_nxt;
      start_ms_r  <= start_ms_nxt;
      out_valid_r <= out_valid_nxt;
      rdv_r       <= rdv_nxt;
      rd_k_r      <= rd_k_nxt;
      if (cfg_valid && cfg_ready) begin
        pts_r <= cfg_points_in_use;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_temp_r   <= out_temp_nxt;
    out_run_r    <= out_run_nxt;
    elapsed_r    <= elapsed_nxt;
    ev_k_r       <= ev_k_nxt;
    prev_time_r  <= prev_time_nxt;
    prev_temp_r  <= prev_temp_nxt;
    first_temp_r <= first_temp_nxt;
    base_temp_r  <= base_temp_nxt;
    neg_r        <= neg_nxt;
    den_r        <= den_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_setpoint = out_temp_r;
  assign out_running  = out_run_r;

endmodule
